// ===== rtl/vpf_pkg.sv =====
// Shared constants, types and helpers for the varint packet framer.
`timescale 1ns / 1ps

package vpf_pkg;

   localparam int LENGTH_BITS = 21;
   localparam int ID_W        = 32;
   localparam int BYTE_W      = 8;
   localparam int GROUP_W     = 7;
   // length prefix = id varint size (at most 5) + payload length
   localparam int TOT_W       = LENGTH_BITS + 1;
   localparam int SER_W       = (ID_W > TOT_W) ? ID_W : TOT_W;
   localparam int SIZE_W      = 3;

   // request tdata layout, lowest bit first
   localparam int ID_LSB      = 0;
   localparam int PLEN_LSB    = ID_LSB + ID_W;
   localparam int PBYTE_LSB   = PLEN_LSB + LENGTH_BITS;
   localparam int REQ_BITS    = PBYTE_LSB + BYTE_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   localparam logic MODE_HEADER  = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_ID
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } ser_ctrl_type;

   // number of 7-bit groups in the varint of a 32-bit value
   function automatic logic [SIZE_W-1:0] varint_size(input logic [ID_W-1:0] v);
      logic [SIZE_W-1:0] n;
      if (v[31:28] != '0) n = SIZE_W'(5);
      else if (v[27:21] != '0) n = SIZE_W'(4);
      else if (v[20:14] != '0) n = SIZE_W'(3);
      else if (v[13:7] != '0) n = SIZE_W'(2);
      else n = SIZE_W'(1);
      return n;
   endfunction

endpackage

// ===== rtl/varint_packet_framer.sv =====
// Top level of the varint packet framer.
`timescale 1ns / 1ps
//
// Builds length-prefixed packets as a byte stream.
// req_*: items in. tuser = mode (0 header, 1 payload byte). A header carries
//   packet id and payload length; a payload item carries one raw byte.
// rsp_*: one framed byte per transfer in tdata, tlast on the final byte of a
//   packet, tuser flags a payload byte that arrived with no open packet.
// A header is answered by varint(id size + length) then varint(id), one byte
// per cycle unless the receiver stalls, out of a 7-bit-per-step shift register;
// it holds the input off until its 2 to 9 header bytes are out. Payload bytes
// pass at one per cycle unless the receiver stalls. A payload result is
// registered at its accepting edge; the first header byte once the shift loads.
// The output register lets a new item be taken in the cycle its result is
// taken; while the receiver stalls, the held byte stays and no input is taken.
// A new header abandons any unfinished packet.
// Reset (synchronous, active high) empties the output and closes any packet.
//
module varint_packet_framer
   import vpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // packet_id, payload_length, payload_byte
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,  // out_byte
   output logic                  rsp_tlast,  // last
   output logic                  rsp_tuser   // error
);

   state_type state_ff, state_in;

   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                   open_ff, open_in;
   logic [ID_W-1:0]        id_ff;
   logic                   plen_zero_ff;

   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic                   emit;

   ser_ctrl_type           ser_ctrl;
   logic [SER_W-1:0]       ser_value;
   logic [GROUP_W-1:0]     ser_group;
   logic                   ser_more;

   logic [ID_W-1:0]        req_id;
   logic [LENGTH_BITS-1:0] req_plen;
   logic [BYTE_W-1:0]      req_byte;
   logic                   slot_free;
   logic                   req_fire;
   logic [TOT_W-1:0]       total;
   logic [LENGTH_BITS-1:0] rem_dec;

   assign req_id   = req_tdata[ID_LSB +: ID_W];
   assign req_plen = req_tdata[PLEN_LSB +: LENGTH_BITS];
   assign req_byte = req_tdata[PBYTE_LSB +: BYTE_W];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;

   assign total   = TOT_W'(req_plen) + TOT_W'(varint_size(req_id));
   assign rem_dec = rem_ff - LENGTH_BITS'(1);

   vpf_varint_ser u_ser (
      .clock      (clock),
      .ctrl       (ser_ctrl),
      .load_value (ser_value),
      .group      (ser_group),
      .more       (ser_more)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == MODE_HEADER) state_in = ST_LEN;
         end
         ST_LEN: begin
            if (slot_free && !ser_more) state_in = ST_ID;
         end
         ST_ID: begin
            if (slot_free && !ser_more) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      emit          = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      ser_ctrl      = '0;
      ser_value     = SER_W'(total);
      rem_in        = rem_ff;
      open_in       = open_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == MODE_HEADER) begin
                  ser_ctrl.load = 1'b1;
                  rem_in        = req_plen;
                  open_in       = (req_plen != '0);
               end else if (!open_ff || rem_ff == '0) begin
                  emit        = 1'b1;
                  rsp_byte_in = '0;
                  rsp_last_in = 1'b0;
                  rsp_err_in  = 1'b1;
                  rem_in      = '0;
                  open_in     = 1'b0;
               end else begin
                  emit        = 1'b1;
                  rsp_byte_in = req_byte;
                  rsp_last_in = (rem_dec == '0);
                  rsp_err_in  = 1'b0;
                  rem_in      = rem_dec;
                  open_in     = (rem_dec != '0);
               end
            end
         end
         ST_LEN: begin
            if (slot_free) begin
               emit           = 1'b1;
               rsp_byte_in    = {ser_more, ser_group};
               rsp_last_in    = 1'b0;
               rsp_err_in     = 1'b0;
               ser_ctrl.shift = 1'b1;
               // length prefix done: bring in the id
               if (!ser_more) begin
                  ser_ctrl.load = 1'b1;
                  ser_value     = SER_W'(id_ff);
               end
            end
         end
         ST_ID: begin
            if (slot_free) begin
               emit           = 1'b1;
               rsp_byte_in    = {ser_more, ser_group};
               rsp_last_in    = !ser_more && plen_zero_ff;
               rsp_err_in     = 1'b0;
               ser_ctrl.shift = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         open_ff  <= open_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (req_fire && req_tuser == MODE_HEADER) begin
         id_ff        <= req_id;
         plen_zero_ff <= (req_plen == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken while a header is being framed");

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (rem_ff != '0))
      else $error("open packet with no bytes remaining");

   a_error_byte_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_byte_ff == '0 && !rsp_last_ff))
      else $error("error transfer carries data or last");

   a_header_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == MODE_HEADER) |=> (state_ff == ST_LEN))
      else $error("header did not start the length prefix");

endmodule

// ===== rtl/vpf_varint_ser.sv =====
// Varint serializer: shift register that yields one 7-bit group per step.
`timescale 1ns / 1ps

module vpf_varint_ser
   import vpf_pkg::*;
(
   input  logic               clock,
   input  ser_ctrl_type       ctrl,
   input  logic [SER_W-1:0]   load_value,
   output logic [GROUP_W-1:0] group,
   output logic               more
);

   logic [SER_W-1:0] sr_ff;
   logic [SER_W-1:0] sr_in;

   always_comb begin
      sr_in = sr_ff;
      if (ctrl.load) begin
         sr_in = load_value;
      end else if (ctrl.shift) begin
         sr_in = sr_ff >> GROUP_W;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign group = sr_ff[GROUP_W-1:0];
   assign more  = (sr_ff[SER_W-1:GROUP_W] != '0);

endmodule

// ===== bench/tb_varint_packet_framer.sv =====
// Self-checking testbench for the varint packet framer: directed table, then random packets.
`timescale 1ns / 1ps

module tb_varint_packet_framer;
   import vpf_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int MAX_CYCLES  = 200_000;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_REPORTS = 40;
   localparam int DUE_DEPTH   = 256;
   localparam int PRED_DEPTH  = 10;
   localparam int DIR_DEPTH   = 32;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              err;
   } frame_byte_type;

   // typed holds up to six hand-written results, first one in the highest used slot
   typedef struct packed {
      logic                   mode;
      logic [ID_W-1:0]        id;
      logic [LENGTH_BITS-1:0] plen;
      logic [BYTE_W-1:0]      pbyte;
      logic [3:0]             n_typed;
      logic [59:0]            typed;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // packet_id, payload_length, payload_byte
   logic                  req_tuser  = 1'b0; // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;  // out_byte
   logic                  rsp_tlast;  // last
   logic                  rsp_tuser;  // error

   // predictor state
   logic [LENGTH_BITS-1:0] pay_left = '0;
   logic                   pkt_open = 1'b0;

   // outstanding bytes, ring buffer
   frame_byte_type due_mem [DUE_DEPTH];
   int             due_wr = 0;
   int             due_rd = 0;

   frame_byte_type pred_buf [PRED_DEPTH];
   int             pred_n = 0;

   stim_row_type   directed_rows [DIR_DEPTH];
   int             n_dir = 0;

   int errors        = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   varint_packet_framer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic frame_byte_type fb(logic [BYTE_W-1:0] d, logic l, logic e);
      return {d, l, e};
   endfunction

   function automatic stim_row_type row(logic mode, logic [ID_W-1:0] id,
                                        logic [LENGTH_BITS-1:0] plen,
                                        logic [BYTE_W-1:0] pbyte,
                                        int n_typed, logic [59:0] typed);
      stim_row_type r;
      r.mode    = mode;
      r.id      = id;
      r.plen    = plen;
      r.pbyte   = pbyte;
      r.n_typed = 4'(n_typed);
      r.typed   = typed;
      return r;
   endfunction

   function automatic void add_row(stim_row_type r);
      directed_rows[n_dir] = r;
      n_dir++;
   endfunction

   function automatic void due_add(frame_byte_type b);
      due_mem[due_wr % DUE_DEPTH] = b;
      due_wr++;
   endfunction

   function automatic void pred_add(frame_byte_type b);
      pred_buf[pred_n] = b;
      pred_n++;
   endfunction

   function automatic int varint_bytes(logic [31:0] v);
      int n;
      n = 1;
      while (v > 32'h7F) begin
         v = v >> GROUP_W;
         n++;
      end
      return n;
   endfunction

   function automatic void put_varint(logic [31:0] v, logic mark_last);
      logic [31:0] cur;
      logic [31:0] rest;
      cur = v;
      do begin
         rest = cur >> GROUP_W;
         pred_add(fb({rest != 0, cur[GROUP_W-1:0]}, (rest == 0) & mark_last, 1'b0));
         cur = rest;
      end while (cur != 0);
   endfunction

   // expected bytes for one accepted item, left in pred_buf
   function automatic void predict_frame(stim_row_type r);
      logic [31:0] total;
      pred_n = 0;
      if (r.mode == MODE_HEADER) begin
         total = 32'(varint_bytes(r.id)) + 32'(r.plen);
         put_varint(total, 1'b0);
         put_varint(r.id, r.plen == 0);
         pay_left = r.plen;
         pkt_open = (r.plen != 0);
      end else if (!pkt_open || pay_left == 0) begin
         pkt_open = 1'b0;
         pay_left = '0;
         pred_add(fb('0, 1'b0, 1'b1));
      end else begin
         pay_left = pay_left - 1'b1;
         if (pay_left == 0) pkt_open = 1'b0;
         pred_add(fb(r.pbyte, pay_left == 0, 1'b0));
      end
   endfunction

   task automatic offer_item(stim_row_type r);
      int i;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= REQ_DATA_W'({r.pbyte, r.plen, r.id});
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_frame(r);
      if (r.n_typed != 0) begin
         for (i = 0; i < int'(r.n_typed); i++)
            due_add(r.typed[(int'(r.n_typed) - 1 - i) * 10 +: 10]);
      end else begin
         for (i = 0; i < pred_n; i++) due_add(pred_buf[i]);
      end
      items_sent++;
   endtask

   // hold the sender off until every outstanding byte has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
   endtask

   task automatic random_packets(int count);
      int target;
      int w;
      int q;
      int n_pay;
      int k;
      logic [ID_W-1:0] id;
      logic [LENGTH_BITS-1:0] plen;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 8) begin
            // stray byte: error when closed, otherwise eats into the open packet
            offer_item(row(MODE_PAYLOAD, $urandom, 21'($urandom), 8'($urandom), 0, '0));
         end else begin
            w  = $urandom_range(32);
            id = $urandom & 32'((64'd1 << w) - 1);
            q  = $urandom_range(99);
            if (q < 60) plen = 21'($urandom_range(4));
            else if (q < 85) plen = 21'($urandom_range(20, 5));
            else if (q < 95) plen = 21'($urandom_range(60, 21));
            else plen = 21'($urandom);
            q = $urandom_range(99);
            if (plen > 60) n_pay = $urandom_range(12);
            else if (q < 80) n_pay = int'(plen);
            else if (q < 90) n_pay = $urandom_range(int'(plen));
            else n_pay = int'(plen) + int'($urandom_range(2, 1));
            offer_item(row(MODE_HEADER, id, plen, 8'($urandom), 0, '0));
            for (k = 0; k < n_pay; k++)
               offer_item(row(MODE_PAYLOAD, $urandom, 21'($urandom), 8'($urandom), 0, '0));
         end
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (due_wr == due_rd) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected transfer, expected none, actual %02h/%0b/%0b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = due_mem[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                rsp_tuser !== want.err) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: data/last/error expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                           $time, want.data, want.last, want.err,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   initial begin
      #(MAX_CYCLES * CLK_PERIOD);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int i;
      // after reset, extremes, empty packets, abandoned packets, stray bytes
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'hFF, 1, 60'(fb(8'h00, 1'b0, 1'b1))));
      add_row(row(MODE_HEADER, 32'h0, 21'd0, 8'h00, 2,
                  60'({fb(8'h01, 1'b0, 1'b0), fb(8'h00, 1'b1, 1'b0)})));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h00, 1, 60'(fb(8'h00, 1'b0, 1'b1))));
      add_row(row(MODE_HEADER, 32'hFFFF_FFFF, 21'd0, 8'h00, 6,
                  {fb(8'h05, 1'b0, 1'b0), fb(8'hFF, 1'b0, 1'b0),
                   fb(8'hFF, 1'b0, 1'b0), fb(8'hFF, 1'b0, 1'b0),
                   fb(8'hFF, 1'b0, 1'b0), fb(8'h0F, 1'b1, 1'b0)}));
      add_row(row(MODE_HEADER, 32'd127, 21'd1, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'hFF, 1, 60'(fb(8'hFF, 1'b1, 1'b0))));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h11, 1, 60'(fb(8'h00, 1'b0, 1'b1))));
      add_row(row(MODE_HEADER, 32'd128, 21'd3, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'hA5, 0, '0));
      add_row(row(MODE_HEADER, 32'h1234_5678, 21'h1F_FFFF, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h5A, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h81, 0, '0));
      add_row(row(MODE_HEADER, 32'd16383, 21'd2, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h80, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h7F, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h3C, 1, 60'(fb(8'h00, 1'b0, 1'b1))));
      add_row(row(MODE_HEADER, 32'h0FFF_FFFF, 21'd127, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h3C, 0, '0));
      add_row(row(MODE_HEADER, 32'd2097151, 21'd128, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'hC3, 0, '0));
      add_row(row(MODE_HEADER, 32'h1000_0000, 21'd1, 8'h00, 0, '0));
      add_row(row(MODE_PAYLOAD, 32'h0, 21'd0, 8'h01, 0, '0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 56;
      for (i = 0; i < n_dir; i++) offer_item(directed_rows[i]);
      drain();
      random_packets(115);
      drain();

      send_idle_pct = 56;
      recv_idle_pct = 27;
      random_packets(115);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_packets(115);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_wr != due_rd) errors++;
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
